// File: src/nsf_pkg.sv
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared constants, event codes and the result word type of the sentence
// framer.
// ----------------------------------------------------------------------------
package nsf_pkg;

    localparam int FIELD_BUF = 32;
    localparam int COUNT_W   = 5;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    localparam logic [3:0] EV_KEPT   = 4'd0;
    localparam logic [3:0] EV_FIELD  = 4'd1;
    localparam logic [3:0] EV_START  = 4'd2;
    localparam logic [3:0] EV_OK     = 4'd3;
    localparam logic [3:0] EV_CR     = 4'd4;
    localparam logic [3:0] EV_PARSE  = 4'd5;
    localparam logic [3:0] EV_CSUM   = 4'd6;
    localparam logic [3:0] EV_FULL   = 4'd7;
    localparam logic [3:0] EV_BINARY = 4'd8;
    localparam logic [3:0] EV_BAUD   = 4'd9;
    localparam logic [3:0] EV_HALTED = 4'd10;

    typedef struct packed {
        logic [3:0]         event_res;
        logic [7:0]         byte_out;
        logic [7:0]         field_number;
        logic [COUNT_W-1:0] field_offset;
        logic               in_checksum;
        logic [7:0]         computed_sum;
        logic [7:0]         received_sum;
    } nsf_result_t;

    // {bad, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        begin
            r = 5'h10;
            if (b >= 8'h30 && b <= 8'h39) begin
                r = {1'b0, 4'(b - 8'h30)};
            end else if (b >= 8'h41 && b <= 8'h46) begin
                r = {1'b0, 4'(b - 8'h37)};
            end else if (b >= 8'h61 && b <= 8'h66) begin
                r = {1'b0, 4'(b - 8'h57)};
            end
            return r;
        end
    endfunction

endpackage

// File: src/nmea_sentence_framer.sv
// ----------------------------------------------------------------------------
// nmea_sentence_framer
// Frames NMEA 0183 sentences from a byte stream and checks the XOR checksum,
// producing one event word per received byte.
// ----------------------------------------------------------------------------
// One byte is taken per clock while s_ready is high, and every byte yields
// exactly one event word. A byte is held in an input register, the framing
// update runs as combinational logic against the sentence context, and the
// event word is held in an output register. A word taken on s_ passes
// through the input register and then the output register before it shows
// on m_. Throughput is one word per cycle while m_ready is high; with
// m_ready low the two registers fill and s_ready drops. The non-printable
// limit (cfg_wr_data, reset 16) should be written only while no word is in
// flight. After a wrong-baud halt every byte reports "halted" until reset.
module nmea_sentence_framer
    import nsf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_event_res,
    output logic [7:0]         m_byte_out,
    output logic [7:0]         m_field_number,
    output logic [COUNT_W-1:0] m_field_offset,
    output logic               m_in_checksum,
    output logic [7:0]         m_computed_sum,
    output logic [7:0]         m_received_sum
);

    logic [7:0]  binary_limit_reg;
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    nsf_result_t out_reg;
    nsf_result_t step_res;
    logic        advance;
    logic        take;

    // move the held word forward when the output slot is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign take    = s_valid && s_ready;

    assign in_valid_next  = take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    nsf_step u_step (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (advance),
        .data_byte    (in_byte_reg),
        .binary_limit (binary_limit_reg),
        .result       (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            binary_limit_reg <= 8'd16;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                binary_limit_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_byte_reg <= s_data_byte;
        end
        if (advance) begin
            out_reg <= step_res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_event_res    = out_reg.event_res;
    assign m_byte_out     = out_reg.byte_out;
    assign m_field_number = out_reg.field_number;
    assign m_field_offset = out_reg.field_offset;
    assign m_in_checksum  = out_reg.in_checksum;
    assign m_computed_sum = out_reg.computed_sum;
    assign m_received_sum = out_reg.received_sum;

endmodule

// File: src/nsf_step.sv
// ----------------------------------------------------------------------------
// nsf_step
// Sentence context registers and the per-byte update: classifies the byte,
// advances the framing state and forms the result word.
// ----------------------------------------------------------------------------
module nsf_step
    import nsf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  binary_limit,
    output nsf_result_t result
);

    logic               started_reg, started_next;
    logic               ck_phase_reg, ck_phase_next;
    logic               cr_seen_reg, cr_seen_next;
    logic               halted_reg, halted_next;
    logic [7:0]         field_idx_reg, field_idx_next;
    logic [7:0]         xor_reg, xor_next;
    logic [COUNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic [7:0]         bin_cnt_reg, bin_cnt_next;
    logic [7:0]         hex_acc_reg, hex_acc_next;
    logic               hex_bad_reg, hex_bad_next;

    logic               in_body;
    logic [4:0]         hex;
    logic [3:0]         ev;
    logic [COUNT_W-1:0] offs;
    logic               inck;

    assign in_body = started_reg && !ck_phase_reg && !cr_seen_reg;
    assign hex     = hex_digit(data_byte);

    always_comb begin
        started_next   = started_reg;
        ck_phase_next  = ck_phase_reg;
        cr_seen_next   = cr_seen_reg;
        halted_next    = halted_reg;
        field_idx_next = field_idx_reg;
        xor_next       = xor_reg;
        byte_cnt_next  = byte_cnt_reg;
        bin_cnt_next   = bin_cnt_reg;
        hex_acc_next   = hex_acc_reg;
        hex_bad_next   = hex_bad_reg;
        ev             = EV_KEPT;
        offs           = '0;
        inck           = 1'b0;

        priority if (halted_reg) begin
            ev = EV_HALTED;
        end else if (data_byte == CH_DOLLAR) begin
            started_next   = 1'b1;
            ck_phase_next  = 1'b0;
            cr_seen_next   = 1'b0;
            field_idx_next = '0;
            xor_next       = '0;
            bin_cnt_next   = '0;
            byte_cnt_next  = '0;
            hex_acc_next   = '0;
            hex_bad_next   = 1'b0;
            ev             = EV_START;
        end else if (data_byte == CH_COMMA || data_byte == CH_STAR) begin
            if (!in_body) begin
                started_next  = 1'b0;
                ck_phase_next = 1'b0;
                cr_seen_next  = 1'b0;
                ev            = EV_PARSE;
            end else begin
                byte_cnt_next = '0;
                if (data_byte == CH_COMMA) begin
                    xor_next = xor_reg ^ data_byte;
                    if (field_idx_reg != 8'hFF) begin
                        field_idx_next = field_idx_reg + 8'd1;
                    end
                end else begin
                    ck_phase_next = 1'b1;
                    hex_acc_next  = '0;
                    hex_bad_next  = 1'b0;
                end
                ev = EV_FIELD;
            end
        end else if (data_byte == CH_CR) begin
            priority if (cr_seen_reg || !started_reg) begin
                started_next  = 1'b0;
                ck_phase_next = 1'b0;
                cr_seen_next  = 1'b0;
                ev            = EV_PARSE;
            end else if (ck_phase_reg) begin
                priority if (byte_cnt_reg != COUNT_W'(2) || hex_bad_reg) begin
                    started_next  = 1'b0;
                    ck_phase_next = 1'b0;
                    cr_seen_next  = 1'b0;
                    ev            = EV_PARSE;
                end else if (hex_acc_reg != xor_reg) begin
                    started_next  = 1'b0;
                    ck_phase_next = 1'b0;
                    cr_seen_next  = 1'b0;
                    ev            = EV_CSUM;
                end else begin
                    cr_seen_next = 1'b1;
                    ev           = EV_CR;
                end
            end else begin
                cr_seen_next = 1'b1;
                ev           = EV_CR;
            end
        end else if (data_byte == CH_LF) begin
            started_next  = 1'b0;
            ck_phase_next = 1'b0;
            cr_seen_next  = 1'b0;
            ev            = (started_reg && cr_seen_reg) ? EV_OK : EV_PARSE;
        end else if (data_byte < CH_SPACE || data_byte > CH_TILDE) begin
            if (bin_cnt_reg != 8'hFF) begin
                bin_cnt_next = bin_cnt_reg + 8'd1;
            end
            started_next  = 1'b0;
            ck_phase_next = 1'b0;
            cr_seen_next  = 1'b0;
            if (bin_cnt_next > binary_limit) begin
                halted_next = 1'b1;
                ev          = EV_BAUD;
            end else begin
                ev = EV_BINARY;
            end
        end else if (!started_reg) begin
            started_next  = 1'b0;
            ck_phase_next = 1'b0;
            cr_seen_next  = 1'b0;
            ev            = EV_PARSE;
        end else if (byte_cnt_reg >= COUNT_W'(FIELD_BUF - 1)) begin
            ev = EV_FULL;
        end else begin
            if (in_body) begin
                xor_next = xor_reg ^ data_byte;
            end else if (ck_phase_reg && !cr_seen_reg) begin
                if (hex[4]) begin
                    hex_bad_next = 1'b1;
                end else begin
                    hex_acc_next = {hex_acc_reg[3:0], hex[3:0]};
                end
            end
            offs          = byte_cnt_reg;
            inck          = ck_phase_reg;
            byte_cnt_next = byte_cnt_reg + COUNT_W'(1);
            ev            = EV_KEPT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg   <= 1'b0;
            ck_phase_reg  <= 1'b0;
            cr_seen_reg   <= 1'b0;
            halted_reg    <= 1'b0;
            field_idx_reg <= '0;
            xor_reg       <= '0;
            byte_cnt_reg  <= '0;
            bin_cnt_reg   <= '0;
            hex_acc_reg   <= '0;
            hex_bad_reg   <= 1'b0;
        end else if (fire) begin
            started_reg   <= started_next;
            ck_phase_reg  <= ck_phase_next;
            cr_seen_reg   <= cr_seen_next;
            halted_reg    <= halted_next;
            field_idx_reg <= field_idx_next;
            xor_reg       <= xor_next;
            byte_cnt_reg  <= byte_cnt_next;
            bin_cnt_reg   <= bin_cnt_next;
            hex_acc_reg   <= hex_acc_next;
            hex_bad_reg   <= hex_bad_next;
        end
    end

    assign result.event_res    = ev;
    assign result.byte_out     = data_byte;
    assign result.field_number = field_idx_next;
    assign result.field_offset = offs;
    assign result.in_checksum  = inck;
    assign result.computed_sum = xor_next;
    assign result.received_sum = hex_acc_next;

endmodule

// File: verif/nmea_sentence_framer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nmea_sentence_framer_test
// Drives received bytes into the sentence framer, mostly as well-formed NMEA
// sentences with random content, some cut short and some plain line noise.
// Every event word is checked against an in-bench model of the framing state.
// Covers random idling on both channels, long output stalls, several settings
// of the non-printable limit, and the wrong-baud halt at the end.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_test;
    import nsf_pkg::*;

    typedef enum int {RX_OPEN, RX_BUSY, RX_CHOKED, RX_RHYTHM} rx_mode_t;

    class framer_scoreboard;
        nsf_result_t due_words[$];
        int unsigned errors;
        int unsigned words_checked;
        int unsigned ev_seen[16];
        logic [7:0]  limit;

        bit          started;
        bit          in_sum;
        bit          cr_seen;
        bit          halted;
        bit          hex_bad;
        logic [7:0]  field_idx;
        logic [7:0]  xor_sum;
        logic [7:0]  bin_count;
        logic [7:0]  hex_acc;
        logic [4:0]  pos;

        function new();
            limit     = 8'd16;
            started   = 1'b0;
            in_sum    = 1'b0;
            cr_seen   = 1'b0;
            halted    = 1'b0;
            hex_bad   = 1'b0;
            field_idx = '0;
            xor_sum   = '0;
            bin_count = '0;
            hex_acc   = '0;
            pos       = '0;
            errors    = 0;
            words_checked = 0;
            foreach (ev_seen[i]) ev_seen[i] = 0;
        endfunction

        // abandon the sentence, counters stay until the next start
        function void drop_sentence();
            started = 1'b0;
            in_sum  = 1'b0;
            cr_seen = 1'b0;
        endfunction

        function nsf_result_t frame_byte(logic [7:0] b);
            nsf_result_t r;
            logic [3:0]  ev;
            logic [4:0]  offs;
            logic        inck;
            bit          body;
            offs = '0;
            inck = 1'b0;
            body = started && !in_sum && !cr_seen;
            if (halted) begin
                ev = EV_HALTED;
            end else if (b == CH_DOLLAR) begin
                started   = 1'b1;
                in_sum    = 1'b0;
                cr_seen   = 1'b0;
                field_idx = '0;
                xor_sum   = '0;
                bin_count = '0;
                pos       = '0;
                hex_acc   = '0;
                hex_bad   = 1'b0;
                ev = EV_START;
            end else if (b == CH_COMMA || b == CH_STAR) begin
                if (!body) begin
                    drop_sentence();
                    ev = EV_PARSE;
                end else begin
                    pos = '0;
                    if (b == CH_COMMA) begin
                        xor_sum ^= b;
                        if (field_idx != 8'hFF) field_idx++;
                    end else begin
                        in_sum  = 1'b1;
                        hex_acc = '0;
                        hex_bad = 1'b0;
                    end
                    ev = EV_FIELD;
                end
            end else if (b == CH_CR) begin
                if (cr_seen || !started) begin
                    drop_sentence();
                    ev = EV_PARSE;
                end else if (in_sum && (pos != 5'd2 || hex_bad)) begin
                    drop_sentence();
                    ev = EV_PARSE;
                end else if (in_sum && hex_acc != xor_sum) begin
                    drop_sentence();
                    ev = EV_CSUM;
                end else begin
                    cr_seen = 1'b1;
                    ev = EV_CR;
                end
            end else if (b == CH_LF) begin
                ev = (started && cr_seen) ? EV_OK : EV_PARSE;
                drop_sentence();
            end else if (b < CH_SPACE || b > CH_TILDE) begin
                if (bin_count != 8'hFF) bin_count++;
                drop_sentence();
                if (bin_count > limit) begin
                    halted = 1'b1;
                    ev = EV_BAUD;
                end else begin
                    ev = EV_BINARY;
                end
            end else if (!started) begin
                drop_sentence();
                ev = EV_PARSE;
            end else if (pos >= FIELD_BUF - 1) begin
                ev = EV_FULL;
            end else begin
                if (body) begin
                    xor_sum ^= b;
                end else if (in_sum && !cr_seen) begin
                    // digits carry their value in the low nibble, letters low nibble + 9
                    if (b >= "0" && b <= "9") begin
                        hex_acc = {hex_acc[3:0], b[3:0]};
                    end else if ((b >= "A" && b <= "F") || (b >= "a" && b <= "f")) begin
                        hex_acc = {hex_acc[3:0], 4'(b[3:0] + 4'd9)};
                    end else begin
                        hex_bad = 1'b1;
                    end
                end
                offs = pos;
                inck = in_sum;
                pos++;
                ev = EV_KEPT;
            end
            r.event_res    = ev;
            r.byte_out     = b;
            r.field_number = field_idx;
            r.field_offset = offs;
            r.in_checksum  = inck;
            r.computed_sum = xor_sum;
            r.received_sum = hex_acc;
            return r;
        endfunction

        function void note_byte(logic [7:0] b);
            due_words.push_back(frame_byte(b));
        endfunction

        function void check_word(nsf_result_t got);
            nsf_result_t want;
            if (due_words.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected event word %h, nothing pending", got);
                return;
            end
            want = due_words.pop_front();
            words_checked++;
            ev_seen[got.event_res]++;
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("word %0d: expected ev=%0d byte=%h fld=%0d off=%0d ck=%b sum=%h rx=%h",
                             words_checked, want.event_res, want.byte_out, want.field_number,
                             want.field_offset, want.in_checksum, want.computed_sum,
                             want.received_sum);
                    $display("word %0d:      got ev=%0d byte=%h fld=%0d off=%0d ck=%b sum=%h rx=%h",
                             words_checked, got.event_res, got.byte_out, got.field_number,
                             got.field_offset, got.in_checksum, got.computed_sum,
                             got.received_sum);
                end
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [7:0]         cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_data_byte;
    logic               m_valid;
    logic               m_ready;
    logic [3:0]         m_event_res;
    logic [7:0]         m_byte_out;
    logic [7:0]         m_field_number;
    logic [COUNT_W-1:0] m_field_offset;
    logic               m_in_checksum;
    logic [7:0]         m_computed_sum;
    logic [7:0]         m_received_sum;

    nsf_result_t        seen_word;
    framer_scoreboard   sb;
    logic [7:0]         line_q[$];
    int unsigned        burst_left;
    int unsigned        bytes_in;

    nmea_sentence_framer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_byte_out     (m_byte_out),
        .m_field_number (m_field_number),
        .m_field_offset (m_field_offset),
        .m_in_checksum  (m_in_checksum),
        .m_computed_sum (m_computed_sum),
        .m_received_sum (m_received_sum)
    );

    assign seen_word = {m_event_res, m_byte_out, m_field_number, m_field_offset,
                        m_in_checksum, m_computed_sum, m_received_sum};

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // bytes are noted before words are checked, both from pre-edge values
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_byte(s_data_byte);
                bytes_in++;
            end
            if (m_valid && m_ready) sb.check_word(seen_word);
        end
    end

    initial begin : receiver
        rx_mode_t    mode;
        int unsigned run;
        int unsigned cyc;
        int unsigned next_hold;
        m_ready = 1'b0;
        cyc = 0;
        next_hold = 300;
        wait (aresetn === 1'b1);
        forever begin
            if (next_hold != 0 && bytes_in >= next_hold) begin
                // long hold-off so the pipeline backs up into s_ready
                repeat (300) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
                next_hold = (next_hold == 300) ? 1200 : 0;
            end
            mode = rx_mode_t'($urandom_range(RX_OPEN, RX_RHYTHM));
            run = $urandom_range(4, 60);
            repeat (run) begin
                @(negedge aclk);
                cyc++;
                case (mode)
                    RX_OPEN:    m_ready <= 1'b1;
                    RX_BUSY:    m_ready <= ($urandom_range(0, 3) != 0);
                    RX_CHOKED:  m_ready <= ($urandom_range(0, 3) == 0);
                    default:    m_ready <= (cyc % 5 != 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        #(10_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    task automatic send_line();
        foreach (line_q[i]) send_byte(line_q[i]);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.due_words.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_limit(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.limit = v;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return 8'("0" + n);
        return 8'((lower ? "a" : "A") + n - 10);
    endfunction

    // printable, but never a start, separator or checksum marker
    function automatic logic [7:0] body_char();
        logic [7:0] c;
        do c = 8'($urandom_range(CH_SPACE, CH_TILDE));
        while (c == CH_DOLLAR || c == CH_COMMA || c == CH_STAR);
        return c;
    endfunction

    function automatic void add_sentence(input bit clean);
        logic [7:0]  sum;
        logic [7:0]  c;
        int unsigned len;
        int unsigned kind;
        bit          lower;
        sum = '0;
        lower = $urandom_range(0, 1);
        line_q.push_back(CH_DOLLAR);
        len = $urandom_range(1, 6);
        repeat (len) begin
            c = $urandom_range(0, 1) ? 8'($urandom_range("A", "Z"))
                                     : 8'($urandom_range("0", "9"));
            line_q.push_back(c);
            sum ^= c;
        end
        repeat ($urandom_range(0, 8)) begin
            line_q.push_back(CH_COMMA);
            sum ^= CH_COMMA;
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 10);
            repeat (len) begin
                c = body_char();
                line_q.push_back(c);
                sum ^= c;
            end
        end
        kind = clean ? 0 : $urandom_range(0, 99);
        if (kind < 70) begin
            line_q.push_back(CH_STAR);
            line_q.push_back(hex_char(sum[7:4], lower));
            line_q.push_back(hex_char(sum[3:0], lower));
        end else if (kind < 78) begin
            sum ^= 8'($urandom_range(1, 255));
            line_q.push_back(CH_STAR);
            line_q.push_back(hex_char(sum[7:4], lower));
            line_q.push_back(hex_char(sum[3:0], lower));
        end else if (kind < 88) begin
            // malformed checksum field
            line_q.push_back(CH_STAR);
            case ($urandom_range(0, 3))
                0: line_q.push_back(hex_char(sum[7:4], lower));
                1: begin
                    line_q.push_back(hex_char(sum[7:4], lower));
                    line_q.push_back(hex_char(sum[3:0], lower));
                    line_q.push_back(hex_char(4'($urandom), lower));
                end
                2: begin
                    line_q.push_back(lower ? "g" : "G");
                    line_q.push_back(hex_char(sum[3:0], lower));
                end
                default: ;
            endcase
        end
        kind = clean ? 0 : $urandom_range(0, 99);
        if (kind < 90) begin
            line_q.push_back(CH_CR);
            line_q.push_back(CH_LF);
        end else if (kind < 94) begin
            line_q.push_back(CH_CR);
            line_q.push_back(body_char());
            line_q.push_back(CH_LF);
        end else if (kind < 96) begin
            line_q.push_back(CH_CR);
            line_q.push_back(CH_CR);
            line_q.push_back(CH_LF);
        end else if (kind < 98) begin
            line_q.push_back(CH_CR);
        end else begin
            line_q.push_back(CH_LF);
        end
    endfunction

    task automatic random_traffic(input int unsigned n_bytes);
        int unsigned sent;
        int unsigned pick;
        int unsigned cut;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(0, 99);
            line_q.delete();
            if (pick < 88) begin
                add_sentence(1'b0);
                if (pick >= 76) begin
                    // cut short, the next start recovers
                    cut = $urandom_range(1, line_q.size() - 1);
                    while (line_q.size() > cut) void'(line_q.pop_back());
                end
            end else begin
                repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom));
            end
            send_line();
            sent += line_q.size();
        end
    endtask

    initial begin : stimulus
        sb = new();
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        burst_left  = 0;
        bytes_in    = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // good sentence, binary bytes, stray framing bytes, star in checksum, second cr
        line_q = '{CH_DOLLAR, "G", "P", CH_COMMA, "7", CH_STAR, "0", "c", CH_CR, CH_LF,
                   8'h00, 8'hFF, 8'h7F, 8'h1F, CH_COMMA, CH_TILDE, CH_CR, CH_LF,
                   CH_DOLLAR, CH_STAR, CH_STAR, CH_DOLLAR, "A", CH_CR, CH_CR};
        send_line();
        wait_idle();

        set_limit(8'd255);
        random_traffic(620);
        wait_idle();

        set_limit(8'($urandom_range(24, 200)));
        // enough fields to saturate the field index
        line_q.delete();
        line_q.push_back(CH_DOLLAR);
        line_q.push_back("X");
        repeat (260) line_q.push_back(CH_COMMA);
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
        send_line();
        random_traffic(480);
        wait_idle();

        set_limit(8'd16);
        random_traffic(450);
        wait_idle();

        // exactly the limit of binary bytes does not halt
        set_limit(8'd3);
        line_q = '{CH_DOLLAR, "Q", 8'h01, 8'h02, 8'h04, CH_DOLLAR};
        send_line();
        wait_idle();

        set_limit(8'd0);
        line_q.delete();
        repeat (3) add_sentence(1'b1);
        line_q.push_back(8'h80);
        repeat (12) line_q.push_back(8'($urandom));
        send_line();
        wait_idle();

        repeat (10) @(posedge aclk);
        $display("checked %0d words from %0d bytes: %0d sentences ok, %0d checksum errors, %0d parse errors",
                 sb.words_checked, bytes_in, sb.ev_seen[EV_OK], sb.ev_seen[EV_CSUM],
                 sb.ev_seen[EV_PARSE]);
        $display("%0d full-field drops, %0d binary drops, %0d halt, %0d bytes refused after halt",
                 sb.ev_seen[EV_FULL], sb.ev_seen[EV_BINARY], sb.ev_seen[EV_BAUD],
                 sb.ev_seen[EV_HALTED]);
        if (sb.errors == 0 && sb.due_words.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
